[rtl/core/button_click_classifier_assert.svh]
// assertion macros used by the click classifier checker
// no dependencies; included by bcc_checker, which holds concurrent assertions
`ifndef BUTTON_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bcc_pkg.sv]
// types, register indices and reset values for the button click classifier
// no dependencies; imported by bcc_step and button_click_classifier
package bcc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdxW  = 3;

  // configuration register indices
  typedef enum logic [IdxW-1:0] {
    REG_ACTIVE_LEVEL    = 3'd0,
    REG_DEGLITCH_MS     = 3'd1,
    REG_DEBOUNCE_MS     = 3'd2,
    REG_LONG_PRESS_MS   = 3'd3,
    REG_DOUBLE_CLICK_MS = 3'd4
  } reg_idx_e;

  // reset values of the configuration registers
  localparam logic            RstActiveLevel   = 1'b0;
  localparam logic [CfgW-1:0] RstDeglitchMs    = 16'd10;
  localparam logic [CfgW-1:0] RstDebounceMs    = 16'd50;
  localparam logic [CfgW-1:0] RstLongPressMs   = 16'd300;
  localparam logic [CfgW-1:0] RstDoubleClickMs = 16'd250;

  typedef struct packed {
    logic            active_level;
    logic [CfgW-1:0] deglitch_ms;
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] long_press_ms;
    logic [CfgW-1:0] double_click_ms;
  } cfg_t;

  typedef struct packed {
    logic             prev_raw;
    logic             glitch_free_level;
    logic             stable_level;
    logic [TimeW-1:0] glitch_stamp;
    logic [TimeW-1:0] switch_stamp;
    logic [TimeW-1:0] push_stamp;
    logic [TimeW-1:0] release_stamp;
    logic             single_block;
    logic             long_block;
  } state_t;

  typedef struct packed {
    logic changed;
    logic press_edge;
    logic release_edge;
    logic is_pressed;
    logic long_press;
    logic double_click;
    logic single_click;
  } result_t;

  localparam state_t StateRst = '{
    prev_raw:          1'b0,
    glitch_free_level: 1'b0,
    stable_level:      1'b0,
    glitch_stamp:      '0,
    switch_stamp:      '0,
    push_stamp:        '0,
    release_stamp:     '0,
    single_block:      1'b1,
    long_block:        1'b0
  };

endpackage

[rtl/core/bcc_step.sv]
// one sample of the deglitch, debounce and click classification logic
// depends on bcc_pkg; purely combinational, state is held by the top level
module bcc_step import bcc_pkg::*; (
  input  cfg_t             cfg_i,
  input  state_t           state_i,
  input  logic             pin_i,
  input  logic [TimeW-1:0] now_i,
  output state_t           state_o,
  output result_t          res_o
);

  logic             held;
  logic             accept_level;
  logic             gfl;
  logic             sw;
  logic             stable;
  logic             on;
  logic             pushed;
  logic             released;
  logic [TimeW-1:0] since_glitch;
  logic [TimeW-1:0] since_switch;
  logic [TimeW-1:0] since_push;
  logic [TimeW-1:0] hold_len;
  logic             push_far;
  logic             sblk;
  logic             lblk;
  logic             single;
  logic             lng;

  // wraparound time differences
  assign since_glitch = now_i - state_i.glitch_stamp;
  assign since_switch = now_i - state_i.switch_stamp;
  assign since_push   = now_i - state_i.push_stamp;
  assign hold_len     = state_i.release_stamp - state_i.push_stamp;
  assign push_far     = since_push >= TimeW'(cfg_i.double_click_ms);

  // deglitch: level must hold longer than the deglitch period
  assign held         = pin_i == state_i.prev_raw;
  assign accept_level = held && (since_glitch > TimeW'(cfg_i.deglitch_ms));
  assign gfl          = accept_level ? pin_i : state_i.glitch_free_level;

  // debounce: switch only once the debounce period has passed
  assign sw       = (gfl != state_i.stable_level) &&
                    (since_switch > TimeW'(cfg_i.debounce_ms));
  assign stable   = sw ? gfl : state_i.stable_level;
  assign on       = stable == cfg_i.active_level;
  assign pushed   = sw && on;
  assign released = sw && !on;

  // single click and long press blocking flags
  always_comb begin
    sblk = pushed ? !push_far : state_i.single_block;
    single = 1'b0;
    if (!sblk) begin
      single = !sw && !on && (hold_len <= TimeW'(cfg_i.long_press_ms)) && push_far;
      sblk   = single;
    end
    lblk = released ? 1'b0 : state_i.long_block;
    lng  = 1'b0;
    if (!lblk) begin
      lng  = !sw && on && (since_push > TimeW'(cfg_i.long_press_ms));
      lblk = lng;
    end
  end

  // next state
  always_comb begin
    state_o                   = state_i;
    state_o.prev_raw          = pin_i;
    state_o.glitch_free_level = gfl;
    state_o.stable_level      = stable;
    state_o.single_block      = sblk;
    state_o.long_block        = lblk;
    if (!held || accept_level) begin
      state_o.glitch_stamp = now_i;
    end
    if (sw) begin
      state_o.switch_stamp = now_i;
      if (pushed) begin
        state_o.push_stamp = now_i;
      end else begin
        state_o.release_stamp = now_i;
      end
    end
  end

  // result flags
  assign res_o = '{
    changed:      sw,
    press_edge:   pushed,
    release_edge: released,
    is_pressed:   on,
    long_press:   lng,
    double_click: pushed && !push_far,
    single_click: single
  };

endmodule

[rtl/core/button_click_classifier.sv]
// top level of the button click classifier: handshakes, registers, state
// depends on bcc_pkg and bcc_step
//
//  channel  signals                                  direction
//  in       in_valid_i, in_stall_o, pin_level_i,     sample word in
//           now_ms_i
//  out      out_valid_o, out_stall_i, changed_o ...  result word out
//           single_click_o
//  cfg      cfg_valid_i, cfg_ready_o, cfg_index_i,   register write in
//           cfg_data_i
//
// one word per cycle while the result is not stalled: input register, then one
// pass of the step logic into the result register.
// the classification state is updated as a word moves into the result register.
// reset (async, active low) clears handshake and classification state and
// loads the register defaults; a stalled result holds the input register,
// and in_stall_o follows out_stall_i in the same cycle once both are full.
module button_click_classifier import bcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             pin_level_i,
  input  logic [TimeW-1:0] now_ms_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             changed_o,
  output logic             press_edge_o,
  output logic             release_edge_o,
  output logic             is_pressed_o,
  output logic             long_press_o,
  output logic             double_click_o,
  output logic             single_click_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]  cfg_data_i
);

  cfg_t             cfg_q;
  state_t           state_q;
  state_t           state_d;
  result_t          res_d;
  result_t          res_q;
  logic             in_vld_q;
  logic             pin_q;
  logic [TimeW-1:0] now_q;
  logic             out_vld_q;
  logic             out_free;
  logic             advance;
  logic             in_acc;

  // handshake control
  assign out_free    = !out_vld_q || !out_stall_i;
  assign advance     = in_vld_q && out_free;
  assign in_stall_o  = in_vld_q && !out_free;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{
        active_level:    RstActiveLevel,
        deglitch_ms:     RstDeglitchMs,
        debounce_ms:     RstDebounceMs,
        long_press_ms:   RstLongPressMs,
        double_click_ms: RstDoubleClickMs
      };
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_ACTIVE_LEVEL:    cfg_q.active_level    <= cfg_data_i[0];
        REG_DEGLITCH_MS:     cfg_q.deglitch_ms     <= cfg_data_i;
        REG_DEBOUNCE_MS:     cfg_q.debounce_ms     <= cfg_data_i;
        REG_LONG_PRESS_MS:   cfg_q.long_press_ms   <= cfg_data_i;
        REG_DOUBLE_CLICK_MS: cfg_q.double_click_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_acc || (in_vld_q && !out_free);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pin_q <= pin_level_i;
      now_q <= now_ms_i;
    end
  end

  // step logic
  bcc_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .pin_i   (pin_q),
    .now_i   (now_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // classification state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateRst;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= advance || (out_vld_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign changed_o      = res_q.changed;
  assign press_edge_o   = res_q.press_edge;
  assign release_edge_o = res_q.release_edge;
  assign is_pressed_o   = res_q.is_pressed;
  assign long_press_o   = res_q.long_press;
  assign double_click_o = res_q.double_click;
  assign single_click_o = res_q.single_click;

endmodule

[rtl/core/bcc_checker.sv]
// port-level checks of the button click classifier, bound to the top level
// depends on button_click_classifier_assert.svh
`include "button_click_classifier_assert.svh"

module bcc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_stall_i,
  input logic changed_i,
  input logic press_edge_i,
  input logic release_edge_i,
  input logic is_pressed_i,
  input logic long_press_i,
  input logic double_click_i,
  input logic single_click_i,
  input logic cfg_valid_i,
  input logic cfg_ready_i
);

  logic out_acc;
  logic seen_q;
  logic pressed_q;
  logic long_seen_q;

  assign out_acc = out_valid_i && !out_stall_i;

  // last delivered pressed level, forgotten on any register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= 1'b0;
      pressed_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_i) begin
      seen_q <= 1'b0;
    end else if (out_acc) begin
      seen_q    <= 1'b1;
      pressed_q <= is_pressed_i;
    end
  end

  // long press seen since the last delivered release
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_seen_q <= 1'b0;
    end else if (out_acc) begin
      if (release_edge_i) begin
        long_seen_q <= 1'b0;
      end else if (long_press_i) begin
        long_seen_q <= 1'b1;
      end
    end
  end

  `BCC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i,
    out_valid_i && $stable({changed_i, press_edge_i, release_edge_i, is_pressed_i,
    long_press_i, double_click_i, single_click_i}), "stalled result changed")
  `BCC_ASSERT_NOW(a_level_steady, clk_i, rst_ni, out_acc && seen_q && !changed_i,
    is_pressed_i == pressed_q, "pressed level moved without a change")
  `BCC_ASSERT_NOW(a_long_once, clk_i, rst_ni, out_acc && long_press_i,
    !long_seen_q && is_pressed_i && !changed_i, "long press repeated in one hold")
  `BCC_ASSERT_NOW(a_double_push, clk_i, rst_ni, out_valid_i && double_click_i,
    press_edge_i && changed_i && !single_click_i, "double click without a push")

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .changed_i      (changed_o),
  .press_edge_i   (press_edge_o),
  .release_edge_i (release_edge_o),
  .is_pressed_i   (is_pressed_o),
  .long_press_i   (long_press_o),
  .double_click_i (double_click_o),
  .single_click_i (single_click_o),
  .cfg_valid_i    (cfg_valid_i),
  .cfg_ready_i    (cfg_ready_o)
);
